[hdl/blst_pkg.sv]
// shared types, constants and table sizes for the logistic survival test
`timescale 1ns / 1ps
package blst_pkg;

	localparam int SPECIES_COUNT = 16;
	localparam int SP_W = (SPECIES_COUNT > 1) ? $clog2(SPECIES_COUNT) : 1;
	localparam int COEF_DEPTH = SPECIES_COUNT * 2;
	localparam int COEF_AW = $clog2(COEF_DEPTH);

	localparam logic [15:0] THRESH_RESET = 16'd51200;
	localparam logic [5:0] YEARS_RESET = 6'd1;

	localparam logic CMD_EVAL = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	localparam logic [2:0] SEL_LOW_A = 3'd0;
	localparam logic [2:0] SEL_LOW_B = 3'd1;
	localparam logic [2:0] SEL_HIGH_A = 3'd2;
	localparam logic [2:0] SEL_HIGH_B = 3'd3;
	localparam logic [2:0] SEL_THRESH = 3'd4;

	typedef struct packed {
		logic cmd;
		logic [3:0] species;
		logic [2:0] coef_select;
		logic signed [23:0] coef_value;
		logic [15:0] diameter;
		logic [15:0] light_level;
		logic [15:0] random_value;
	} blst_req_t;

	typedef struct packed {
		logic dead;
		logic [15:0] survival_prob;
	} blst_res_t;

	// control that travels down the pipe with each tree
	typedef struct packed {
		logic valid;
		logic neg;
		logic [15:0] rnd;
	} blst_tag_t;

	function automatic logic [SP_W-1:0] wrap_species(input logic [3:0] s);
		int w;
		w = int'(s) % SPECIES_COUNT;
		return SP_W'(w);
	endfunction

	function automatic logic [COEF_AW-1:0] coef_addr(input logic [SP_W-1:0] sp,
			input logic hi);
		int w;
		w = int'(sp) * 2 + int'(hi);
		return COEF_AW'(w);
	endfunction

endpackage

[hdl/blst_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
module blst_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hdl/blst_exp.sv]
// logit x = a + b*d/64 and t = e^-|x| through polynomial and eight squarings
`timescale 1ns / 1ps
module blst_exp (
	input logic clk,
	input logic arst_n,
	input blst_pkg::blst_tag_t tag_in,
	input logic signed [23:0] coef_a,
	input logic signed [23:0] coef_b,
	input logic [15:0] diam,
	output blst_pkg::blst_tag_t tag_out,
	output logic [31:0] t_out
);
	import blst_pkg::*;

	localparam logic [55:0] C24 = 56'd178956970;
	localparam logic [29:0] C6 = 30'd715827882;
	localparam logic [31:0] HALF = 32'h8000_0000;
	localparam logic [32:0] ONE = 33'h1_0000_0000;

	blst_tag_t tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7;
	logic signed [40:0] prod_s2;
	logic signed [23:0] a_s2;
	logic signed [34:0] x_s3;
	logic big_s4, big_s5, big_s6, big_s7;
	logic [27:0] u_s4, u_s5, u_s6, u_s7;
	logic [29:0] h1_s5;
	logic [31:0] h2_s6;
	logic [32:0] h3_s7;

	logic signed [40:0] prod_c;
	logic [34:0] y_c;
	logic [55:0] m5_c;
	logic [57:0] m6_c;
	logic [60:0] m7_c, m8_c;
	logic [32:0] e_c;

	blst_tag_t tag_q [0:8];
	logic [31:0] sq_s [0:8];

	assign prod_c = $signed(coef_b) * $signed({1'b0, diam});
	assign y_c = x_s3[34] ? 35'(-x_s3) : 35'(x_s3);
	assign m5_c = 56'(u_s4) * C24;
	assign m6_c = 58'(u_s5) * 58'(h1_s5);
	assign m7_c = 61'(u_s6) * 61'(h2_s6);
	assign m8_c = 61'(u_s7) * 61'(h3_s7);
	assign e_c = ONE - 33'(m8_c[60:32]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
			tag_s6 <= '0;
			tag_s7 <= '0;
		end else begin
			tag_s2 <= tag_in;
			tag_s3 <= tag_s2;
			tag_s4 <= '{valid: tag_s3.valid, neg: x_s3[34], rnd: tag_s3.rnd};
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
			tag_s7 <= tag_s6;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod_c;
		a_s2 <= coef_a;
		// floor division by 64 is the arithmetic shift
		x_s3 <= 35'(a_s2) + $signed(prod_s2[40:6]);
		big_s4 <= |y_c[34:20];
		u_s4 <= {y_c[19:0], 8'b0};
		big_s5 <= big_s4;
		u_s5 <= u_s4;
		h1_s5 <= C6 - 30'(m5_c[55:32]);
		big_s6 <= big_s5;
		u_s6 <= u_s5;
		h2_s6 <= HALF - 32'(m6_c[57:32]);
		big_s7 <= big_s6;
		u_s7 <= u_s6;
		h3_s7 <= ONE - 33'(m7_c[60:32]);
		if (big_s7) begin
			sq_s[0] <= '0;
		end else if (e_c[32]) begin
			sq_s[0] <= 32'hFFFF_FFFF;
		end else begin
			sq_s[0] <= e_c[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q[0] <= '0;
		end else begin
			tag_q[0] <= tag_s7;
		end
	end

	for (genvar k = 0; k < 8; k++) begin : g_sq
		logic [63:0] sq_c;
		assign sq_c = 64'(sq_s[k]) * 64'(sq_s[k]);
		always_ff @(posedge clk) begin
			sq_s[k+1] <= sq_c[63:32];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_q[k+1] <= '0;
			end else begin
				tag_q[k+1] <= tag_q[k];
			end
		end
	end

	assign tag_out = tag_q[8];
	assign t_out = sq_s[8];
endmodule

[hdl/blst_div.sv]
// restoring divider, one quotient bit per stage, gives p in q1.31
`timescale 1ns / 1ps
module blst_div (
	input logic clk,
	input logic arst_n,
	input blst_pkg::blst_tag_t tag_in,
	input logic [31:0] t_in,
	output blst_pkg::blst_tag_t tag_out,
	output logic [31:0] quot
);
	import blst_pkg::*;

	blst_tag_t tag_s [0:32];
	logic [32:0] rem_s [0:32];
	logic [31:0] low_s [0:32];
	logic [31:0] q_s [0:32];
	logic [32:0] den_s [0:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s[0] <= '0;
		end else begin
			tag_s[0] <= tag_in;
		end
	end

	// numerator 2^63 for x >= 0, else t * 2^31
	always_ff @(posedge clk) begin
		den_s[0] <= {1'b1, t_in};
		q_s[0] <= '0;
		if (tag_in.neg) begin
			rem_s[0] <= {2'b0, t_in[31:1]};
			low_s[0] <= {t_in[0], 31'b0};
		end else begin
			rem_s[0] <= 33'h0_8000_0000;
			low_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < 32; k++) begin : g_bit
		logic [33:0] sh_c;
		logic [33:0] diff_c;
		logic take_c;
		assign sh_c = {rem_s[k], low_s[k][31]};
		assign diff_c = sh_c - {1'b0, den_s[k]};
		assign take_c = (sh_c >= {1'b0, den_s[k]});
		always_ff @(posedge clk) begin
			rem_s[k+1] <= take_c ? diff_c[32:0] : sh_c[32:0];
			low_s[k+1] <= {low_s[k][30:0], 1'b0};
			q_s[k+1] <= {q_s[k][30:0], take_c};
			den_s[k+1] <= den_s[k];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k+1] <= '0;
			end else begin
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign tag_out = tag_s[32];
	assign quot = q_s[32];
endmodule

[hdl/blst_pow.sv]
// p raised to years per step by square and multiply, one exponent bit a stage
`timescale 1ns / 1ps
module blst_pow (
	input logic clk,
	input logic arst_n,
	input blst_pkg::blst_tag_t tag_in,
	input logic [31:0] p_in,
	input logic [5:0] years,
	output blst_pkg::blst_tag_t tag_out,
	output logic [31:0] pw
);
	import blst_pkg::*;

	blst_tag_t tag_s [0:6];
	logic [31:0] res_s [0:6];
	logic [31:0] base_s [0:6];

	assign tag_s[0] = tag_in;
	assign res_s[0] = 32'h8000_0000;
	assign base_s[0] = p_in;

	for (genvar k = 0; k < 6; k++) begin : g_step
		logic [63:0] mr_c, mb_c;
		assign mr_c = 64'(res_s[k]) * 64'(base_s[k]);
		assign mb_c = 64'(base_s[k]) * 64'(base_s[k]);
		always_ff @(posedge clk) begin
			res_s[k+1] <= years[k] ? mr_c[62:31] : res_s[k];
			base_s[k+1] <= mb_c[62:31];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k+1] <= '0;
			end else begin
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign tag_out = tag_s[6];
	assign pw = res_s[6];
endmodule

[hdl/bilevel_logistic_survival_test_core.sv]
// top level of the two-level logistic survival test
`timescale 1ns / 1ps
// One request enters per clock and busy never rises. An evaluate request gives
// its result at the end of the pipeline, flagged by done for one cycle; the
// depth is set by the 32-stage divider, the eight-step squaring chain of the
// exponential and one stage per exponent bit. Load requests give no result
// and take effect for the very next request. The receiver cannot stall.
module bilevel_logistic_survival_test_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input blst_pkg::blst_req_t req,
	input logic cfg_we,
	input logic [5:0] cfg_wdata,
	output logic done,
	output blst_pkg::blst_res_t res
);
	import blst_pkg::*;

	localparam int LATENCY = 56;

	logic [5:0] years_q;
	logic [15:0] thresh_q [0:SPECIES_COUNT-1];
	logic [SP_W-1:0] sp_c;
	logic acc_c, load_c, hi_c;
	logic we_a_c, we_b_c;
	logic [COEF_AW-1:0] waddr_c, raddr_c;
	logic signed [23:0] a_s1, b_s1;
	logic [15:0] diam_s1;
	blst_tag_t tag_s1, tag_x, tag_d, tag_p;
	logic [31:0] t_x, p_d, pw_p;
	logic [16:0] q_c;

	assign busy = 1'b0;
	assign acc_c = start && !busy;
	assign sp_c = wrap_species(req.species);
	assign load_c = acc_c && (req.cmd == CMD_LOAD);
	assign we_a_c = load_c && (req.coef_select == SEL_LOW_A || req.coef_select == SEL_HIGH_A);
	assign we_b_c = load_c && (req.coef_select == SEL_LOW_B || req.coef_select == SEL_HIGH_B);
	assign waddr_c = coef_addr(sp_c, req.coef_select[1]);
	// below the threshold uses the low-light pair
	assign hi_c = (req.light_level >= thresh_q[sp_c]);
	assign raddr_c = coef_addr(sp_c, hi_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			years_q <= YEARS_RESET;
		end else if (cfg_we) begin
			years_q <= cfg_wdata;
		end
	end

	for (genvar i = 0; i < SPECIES_COUNT; i++) begin : g_thr
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				thresh_q[i] <= THRESH_RESET;
			end else if (load_c && req.coef_select == SEL_THRESH
					&& sp_c == SP_W'(i)) begin
				thresh_q[i] <= req.coef_value[15:0];
			end
		end
	end

	blst_ram #(.WIDTH(24), .DEPTH(COEF_DEPTH)) u_ram_a (
		.clk(clk), .we(we_a_c), .waddr(waddr_c), .wdata(req.coef_value),
		.raddr(raddr_c), .rdata(a_s1)
	);

	blst_ram #(.WIDTH(24), .DEPTH(COEF_DEPTH)) u_ram_b (
		.clk(clk), .we(we_b_c), .waddr(waddr_c), .wdata(req.coef_value),
		.raddr(raddr_c), .rdata(b_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= '{valid: acc_c && (req.cmd == CMD_EVAL), neg: 1'b0,
				rnd: req.random_value};
		end
	end

	always_ff @(posedge clk) begin
		diam_s1 <= req.diameter;
	end

	blst_exp u_exp (
		.clk(clk), .arst_n(arst_n), .tag_in(tag_s1), .coef_a(a_s1),
		.coef_b(b_s1), .diam(diam_s1), .tag_out(tag_x), .t_out(t_x)
	);

	blst_div u_div (
		.clk(clk), .arst_n(arst_n), .tag_in(tag_x), .t_in(t_x),
		.tag_out(tag_d), .quot(p_d)
	);

	blst_pow u_pow (
		.clk(clk), .arst_n(arst_n), .tag_in(tag_d), .p_in(p_d),
		.years(years_q), .tag_out(tag_p), .pw(pw_p)
	);

	assign q_c = pw_p[31:15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= tag_p.valid;
		end
	end

	always_ff @(posedge clk) begin
		res.dead <= ({1'b0, tag_p.rnd} >= q_c);
		res.survival_prob <= q_c[16] ? 16'hFFFF : q_c[15:0];
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && req.cmd == CMD_EVAL, LATENCY))
		else $error("result without a matching evaluate request");

	a_zero_years: assert property (@(posedge clk) disable iff (!arst_n)
		(done && years_q == 6'd0) |-> !res.dead)
		else $error("death reported with zero years per step");
endmodule
